[hdl/iradix_pkg.sv]
// Shared types and constants for the integer to radix digit converter.
// No dependencies; imported by every module of the block but iradix_ram.
`default_nettype none

package iradix_pkg;

	localparam int VALUE_BITS_DEF  = 31;
	localparam int DIGIT_DEPTH_DEF = 32;

	// Dividend bits retired per cycle by the restoring divider.
	localparam int STEP_BITS = 8;

	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
	localparam logic [RADIX_W-1:0] LETTER_RADIX = 5'd16;
	localparam logic [DIGIT_W-1:0] LETTER_LOW   = 4'd10;

	// Register word index (paddr[2]).
	localparam logic REG_RADIX = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic load;    // take a new value, clear counters
		logic step;    // one divider step
		logic finish;  // last step of a digit: store the remainder
		logic read;    // read one stored digit toward the output
	} dp_cmd_t;

	typedef struct packed {
		logic radix_ok;   // radix within two to sixteen
		logic quot_zero;  // quotient after this step is zero
		logic last_read;  // one digit left to read
	} dp_status_t;

endpackage

`default_nettype wire

[hdl/iradix_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module iradix_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/iradix_ctrl.sv]
// Controller: sequences divider passes per digit, then digit readout.
// Depends on iradix_pkg.
`default_nettype none

module iradix_ctrl #(
	parameter int VALUE_BITS = iradix_pkg::VALUE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire iradix_pkg::dp_status_t st,
	output iradix_pkg::dp_cmd_t         cmd
);

	import iradix_pkg::*;

	localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	state_t          state_q, state_d;
	logic [CH_W-1:0] chunk_q;
	logic            chunk_end;

	assign chunk_end = (chunk_q == CH_W'(CHUNKS - 1));
	assign busy      = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				// a request with a bad radix is taken and dropped
				if (start && st.radix_ok) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step   = 1'b1;
				cmd.finish = chunk_end;
				if (chunk_end && st.quot_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.read = 1'b1;
				if (st.last_read) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				chunk_q <= chunk_end ? '0 : chunk_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/iradix_dp.sv]
// Datapath: restoring divider by the radix, digit store and output registers.
// Depends on iradix_pkg and iradix_ram.
`default_nettype none

module iradix_dp #(
	parameter int VALUE_BITS  = iradix_pkg::VALUE_BITS_DEF,
	parameter int DIGIT_DEPTH = iradix_pkg::DIGIT_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire iradix_pkg::dp_cmd_t             cmd,
	output iradix_pkg::dp_status_t               st,
	input  wire logic [iradix_pkg::RADIX_W-1:0]  radix,
	input  wire logic [VALUE_BITS-1:0]           value,
	output logic                                 digit_valid,
	output logic      [iradix_pkg::DIGIT_W-1:0]  digit,
	output logic                                 hex_letter,
	output logic                                 last_digit
);

	import iradix_pkg::*;

	localparam int CHUNKS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int WORK_BITS = CHUNKS * STEP_BITS;
	localparam int AW        = $clog2(DIGIT_DEPTH);
	localparam int CNT_W     = $clog2(DIGIT_DEPTH + 1);

	logic [WORK_BITS-1:0] work_q, work_next;
	logic [DIGIT_W-1:0]   rem_q, rem_next;
	logic [STEP_BITS-1:0] qbits;
	logic [DIGIT_W:0]     r;
	logic [AW-1:0]        wp_q, rp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q, out_last_q;
	logic [DIGIT_W-1:0]   rdata;

	// One restoring step per dividend bit, STEP_BITS bits per cycle.
	always_comb begin
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {r[DIGIT_W-1:0], work_q[WORK_BITS-1-i]};
			if (r >= radix) begin
				r                    = r - radix;
				qbits[STEP_BITS-1-i] = 1'b1;
			end
		end
		rem_next  = r[DIGIT_W-1:0];
		work_next = (work_q << STEP_BITS) | WORK_BITS'(qbits);
	end

	assign st.radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
	assign st.quot_zero = (work_next == '0);
	assign st.last_read = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= WORK_BITS'(value);
			rem_q  <= '0;
		end else if (cmd.step) begin
			work_q <= work_next;
			rem_q  <= cmd.finish ? '0 : rem_next;
		end
	end

	// Store is a ring: once full, the oldest (least significant) digit is overwritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			out_valid_q <= cmd.read;
			out_last_q  <= cmd.read && st.last_read;
			if (cmd.load) begin
				wp_q  <= '0;
				cnt_q <= '0;
			end else if (cmd.step && cmd.finish) begin
				rp_q <= wp_q;
				wp_q <= (wp_q == AW'(DIGIT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (cnt_q != CNT_W'(DIGIT_DEPTH)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (cmd.read) begin
				rp_q  <= (rp_q == '0) ? AW'(DIGIT_DEPTH - 1) : rp_q - 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	iradix_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (DIGIT_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.step && cmd.finish),
		.waddr (wp_q),
		.wdata (rem_next),
		.re    (cmd.read),
		.raddr (rp_q),
		.rdata (rdata)
	);

	assign digit_valid = out_valid_q;
	assign digit       = rdata;
	assign hex_letter  = out_valid_q && (radix == LETTER_RADIX) && (rdata >= LETTER_LOW);
	assign last_digit  = out_valid_q && out_last_q;

endmodule

`default_nettype wire

[hdl/integer_to_radix_digits.sv]
// Top level of the integer to radix digit converter: APB register and core.
// Depends on iradix_pkg, iradix_ctrl and iradix_dp.
`default_nettype none

// A request (start while busy is low) converts value into digits of the base
// held in the radix register (byte address 0, reset 10). Each digit is a full
// pass of the restoring divider over the dividend, which retires eight
// dividend bits per cycle; then the stored digits are read out one per cycle,
// most significant first, the first digit in the cycle after readout starts.
// digit_valid marks each digit for a single cycle and the receiver must take
// it then. A radix outside two to sixteen takes the request and gives no
// digits. Zero gives the digit 0. When more than DIGIT_DEPTH digits arise,
// the most significant DIGIT_DEPTH are delivered. Write the radix only while
// busy is low and no digit is pending.

module integer_to_radix_digits #(
	parameter int VALUE_BITS  = iradix_pkg::VALUE_BITS_DEF,
	parameter int DIGIT_DEPTH = iradix_pkg::DIGIT_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [iradix_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [iradix_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [iradix_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                    pready,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [VALUE_BITS-1:0]              value,
	output logic                                    digit_valid,
	output logic      [iradix_pkg::DIGIT_W-1:0]     digit,
	output logic                                    hex_letter,
	output logic                                    last_digit
);

	import iradix_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	dp_cmd_t            cmd;
	dp_status_t         st;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIX) ? APB_DATA_W'(radix_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX)) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	iradix_ctrl #(
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	iradix_dp #(
		.VALUE_BITS  (VALUE_BITS),
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.radix       (radix_q),
		.value       (value),
		.digit_valid (digit_valid),
		.digit       (digit),
		.hex_letter  (hex_letter),
		.last_digit  (last_digit)
	);

endmodule

`default_nettype wire

[hdl/iradix_checker.sv]
// Port-level checks on the digit output sequence of the converter.
// Depends on iradix_pkg; bound to integer_to_radix_digits.
`default_nettype none

module iradix_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic                           digit_valid,
	input wire logic [iradix_pkg::DIGIT_W-1:0] digit,
	input wire logic                           hex_letter,
	input wire logic                           last_digit
);

	import iradix_pkg::*;

	// digits of one run come back to back
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !last_digit |=> digit_valid)
		else $error("digit run broken before its last digit");

	// more digits pending means the block is still busy
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !last_digit |-> busy)
		else $error("busy dropped in the middle of a digit run");

	// a new request never yields a digit in the next cycle
	a_no_early_digit: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !digit_valid)
		else $error("digit strobe right after a request");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		hex_letter |-> digit_valid && (digit >= LETTER_LOW))
		else $error("letter flag on a digit below ten or without strobe");

endmodule

bind integer_to_radix_digits iradix_checker u_iradix_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.digit_valid (digit_valid),
	.digit       (digit),
	.hex_letter  (hex_letter),
	.last_digit  (last_digit)
);

`default_nettype wire

[tb/sv/integer_to_radix_digits_tb.sv]
`timescale 1ns / 100ps
// Testbench for integer_to_radix_digits: a directed table, then random conversions
// across APB radix changes, every digit checked against a typed expectation or an in-bench predictor.
// Depends on iradix_pkg and the integer_to_radix_digits RTL.

module tb;
	import iradix_pkg::*;

	localparam int VW           = VALUE_BITS_DEF;
	localparam int LIMIT_CYCLES = 400_000;
	localparam int RANDOM_ITEMS = 350;
	localparam int SETTLE       = 8;
	localparam int DRAIN        = 40;
	localparam logic [VW-1:0] MAXV = '1;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               hex_letter;
		logic               last_digit;
	} digit_res_t;

	// Typed expectation: n digits, a leading digit followed by n-1 copies of fill.
	typedef struct {
		logic [RADIX_W-1:0] rdx;
		logic [VW-1:0]      val;
		bit                 known;
		int                 n;
		logic [DIGIT_W-1:0] lead;
		logic [DIGIT_W-1:0] fill;
		bit                 hl_lead;
		bit                 hl_fill;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  start;
	logic                  busy;
	logic [VW-1:0]         value;
	logic                  digit_valid;
	logic [DIGIT_W-1:0]    digit;
	logic                  hex_letter;
	logic                  last_digit;

	// Radix copy, expected digits, and what the driver attaches to the pending request.
	logic [RADIX_W-1:0] radix_cfg = RADIX_RESET;
	logic [RADIX_W-1:0] cur_radix = RADIX_RESET;
	digit_res_t         digits_due [$];
	bit                 pend_known;
	int                 pend_n;
	logic [DIGIT_W-1:0] pend_lead;
	logic [DIGIT_W-1:0] pend_fill;
	bit                 pend_hl_lead;
	bit                 pend_hl_fill;

	int req_count   = 0;
	int wr_count    = 0;
	int rd_count    = 0;
	int fails       = 0;
	int conv_count  = 0;
	int bad_radix   = 0;
	int digits_seen = 0;
	int cycles      = 0;
	int conv_sent   = 0;
	int burst_left  = 0;

	dir_row_t dir_rows [22] = '{
		'{5'd10, 31'd0,          1, 1,  4'd0,  4'd0,  0, 0},
		'{5'd10, MAXV,           0, 0,  4'd0,  4'd0,  0, 0},
		'{5'd10, 31'd9,          1, 1,  4'd9,  4'd0,  0, 0},
		'{5'd2,  MAXV,           1, 31, 4'd1,  4'd1,  0, 0},
		'{5'd2,  31'd1,          1, 1,  4'd1,  4'd0,  0, 0},
		'{5'd2,  31'h4000_0000,  1, 31, 4'd1,  4'd0,  0, 0},
		'{5'd16, MAXV,           1, 8,  4'd7,  4'd15, 0, 1},
		'{5'd16, 31'd15,         1, 1,  4'd15, 4'd0,  1, 0},
		'{5'd16, 31'h1000_0000,  1, 8,  4'd1,  4'd0,  0, 0},
		'{5'd16, 31'h2AAA_AAAA,  0, 0,  4'd0,  4'd0,  0, 0},
		'{5'd8,  MAXV,           1, 11, 4'd1,  4'd7,  0, 0},
		'{5'd4,  MAXV,           1, 16, 4'd1,  4'd3,  0, 0},
		'{5'd3,  31'd1162261467, 1, 20, 4'd1,  4'd0,  0, 0},
		'{5'd15, 31'd14,         1, 1,  4'd14, 4'd0,  0, 0},
		'{5'd11, 31'h5555_5555,  0, 0,  4'd0,  4'd0,  0, 0},
		'{5'd0,  31'd123,        1, 0,  4'd0,  4'd0,  0, 0},
		'{5'd1,  31'd0,          1, 0,  4'd0,  4'd0,  0, 0},
		'{5'd17, MAXV,           1, 0,  4'd0,  4'd0,  0, 0},
		'{5'd31, 31'd5,          1, 0,  4'd0,  4'd0,  0, 0},
		'{5'd10, 31'd1234567890, 0, 0,  4'd0,  4'd0,  0, 0},
		'{5'd9,  31'd0,          1, 1,  4'd0,  4'd0,  0, 0},
		'{5'd16, 31'h7FED_CBA9,  0, 0,  4'd0,  4'd0,  0, 0}
	};

	integer_to_radix_digits DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.digit_valid(digit_valid),
		.digit      (digit),
		.hex_letter (hex_letter),
		.last_digit (last_digit)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit radix_usable(logic [RADIX_W-1:0] b);
		return b >= RADIX_MIN && b <= RADIX_MAX;
	endfunction

	// Divide repeatedly, then queue the remainders most significant first.
	function automatic void predict_digits(logic [VW-1:0] v, logic [RADIX_W-1:0] b);
		logic [DIGIT_W-1:0] rems [DIGIT_DEPTH_DEF];
		longint unsigned    q;
		int                 n;
		digit_res_t         r;
		if (!radix_usable(b))
			return;
		q = v;
		n = 0;
		if (q == 0) begin
			rems[0] = '0;
			n = 1;
		end
		while (q > 0) begin
			rems[n] = DIGIT_W'(q % b);
			n++;
			q = q / b;
		end
		for (int k = 0; k < n; k++) begin
			r.digit      = rems[n - 1 - k];
			r.hex_letter = (b == LETTER_RADIX) && (r.digit >= LETTER_LOW);
			r.last_digit = (k == n - 1);
			digits_due.push_back(r);
		end
	endfunction

	function automatic void queue_typed(int n, logic [DIGIT_W-1:0] lead,
			logic [DIGIT_W-1:0] fill, bit hl_lead, bit hl_fill);
		digit_res_t r;
		for (int k = 0; k < n; k++) begin
			r.digit      = (k == 0) ? lead : fill;
			r.hex_letter = (k == 0) ? hl_lead : hl_fill;
			r.last_digit = (k == n - 1);
			digits_due.push_back(r);
		end
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("integer_to_radix_digits test failed");
			$finish;
		end
	end

	// Sample everything at the rising edge: digits, requests and APB transfers.
	always @(posedge clk) begin
		digit_res_t want;
		if (arst_n) begin
			if (digit_valid !== 1'b0) begin
				if (digits_due.size() == 0) begin
					$error("unexpected digit result: digit %0d", digit);
					fails++;
				end else begin
					want = digits_due.pop_front();
					digits_seen++;
					if (digit !== want.digit) begin
						$error("digit: expected %0d, got %0d", want.digit, digit);
						fails++;
					end
					if (hex_letter !== want.hex_letter) begin
						$error("hex_letter: expected %0d, got %0d", want.hex_letter,
							hex_letter);
						fails++;
					end
					if (last_digit !== want.last_digit) begin
						$error("last_digit: expected %0d, got %0d", want.last_digit,
							last_digit);
						fails++;
					end
				end
			end
			if (start && busy === 1'b0) begin
				req_count++;
				if (radix_usable(radix_cfg))
					conv_count++;
				else
					bad_radix++;
				if (pend_known)
					queue_typed(pend_n, pend_lead, pend_fill, pend_hl_lead, pend_hl_fill);
				else
					predict_digits(value, radix_cfg);
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					radix_cfg = pwdata[RADIX_W-1:0];
					wr_count++;
				end else begin
					if (prdata[RADIX_W-1:0] !== radix_cfg) begin
						$error("radix readback: expected %0d, got %0d", radix_cfg,
							prdata[RADIX_W-1:0]);
						fails++;
					end
					rd_count++;
				end
			end
		end
	end

	// Hold start until the request is taken; then maybe drop it for a gap.
	task automatic send_value(logic [VW-1:0] v, bit known, int n, logic [DIGIT_W-1:0] lead,
			logic [DIGIT_W-1:0] fill, bit hl_lead, bit hl_fill);
		int c;
		int gap;
		value        = v;
		pend_known   = known;
		pend_n       = n;
		pend_lead    = lead;
		pend_fill    = fill;
		pend_hl_lead = hl_lead;
		pend_hl_fill = hl_fill;
		start        = 1'b1;
		c = req_count;
		do @(negedge clk); while (req_count == c);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			burst_left = $urandom_range(1, 10);
			if (gap > 0) begin
				start = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		start = 1'b0;
		repeat (2) @(negedge clk);
		while (digits_due.size() != 0 || busy !== 1'b0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic apb_transfer(bit wr, logic [APB_DATA_W-1:0] data);
		int c;
		psel    = 1'b1;
		pwrite  = wr;
		paddr   = {REG_RADIX, 2'b00};
		pwdata  = data;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		c = wr_count + rd_count;
		do @(negedge clk); while (wr_count + rd_count == c);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_radix(logic [RADIX_W-1:0] r);
		wait_idle();
		apb_transfer(1'b1, APB_DATA_W'(r));
		apb_transfer(1'b0, '0);
		cur_radix = r;
	endtask

	function automatic logic [VW-1:0] rand_value(logic [RADIX_W-1:0] b);
		longint unsigned p;
		int              k;
		logic [VW-1:0]   v;
		case ($urandom_range(0, 5))
			0: v = VW'($urandom_range(0, 300));
			2: v = VW'($urandom >> $urandom_range(1, 31));
			3: begin
				// land next to a power of the radix, where the digit count steps
				p = 1;
				k = $urandom_range(1, 30);
				if (radix_usable(b))
					for (int i = 0; i < k; i++)
						if (p * b <= MAXV)
							p = p * b;
				v = VW'(p + $urandom_range(0, 2) - 1);
			end
			4: v = MAXV - VW'($urandom_range(0, 3));
			default: v = VW'($urandom);
		endcase
		return v;
	endfunction

	initial begin
		logic [RADIX_W-1:0] r;
		int                 len;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		start        = 1'b0;
		value        = '0;
		pend_known   = 1'b0;
		pend_n       = 0;
		pend_lead    = '0;
		pend_fill    = '0;
		pend_hl_lead = 1'b0;
		pend_hl_fill = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		burst_left = $urandom_range(1, 8);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].rdx != cur_radix)
				set_radix(dir_rows[i].rdx);
			send_value(dir_rows[i].val, dir_rows[i].known, dir_rows[i].n, dir_rows[i].lead,
				dir_rows[i].fill, dir_rows[i].hl_lead, dir_rows[i].hl_fill);
		end

		// Phases of random values, each under a fresh radix; a few out of range.
		while (conv_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: r = RADIX_MIN;
				1: r = RADIX_MAX;
				2: r = ($urandom_range(0, 1) == 0) ? RADIX_W'($urandom_range(0, 1))
					: RADIX_W'($urandom_range(17, 31));
				default: r = RADIX_W'($urandom_range(2, 16));
			endcase
			set_radix(r);
			len = radix_usable(r) ? $urandom_range(15, 50) : $urandom_range(3, 6);
			repeat (len)
				send_value(rand_value(r), 1'b0, 0, '0, '0, 1'b0, 1'b0);
			if (radix_usable(r))
				conv_sent += len;
		end

		wait_idle();
		repeat (DRAIN) @(negedge clk);
		$display("Converted %0d values into %0d checked digits over %0d radix writes;",
			conv_count, digits_seen, wr_count);
		$display("%0d requests went in under an out-of-range radix.", bad_radix);
		if (fails == 0)
			$display("integer_to_radix_digits test passed");
		else
			$display("integer_to_radix_digits test failed");
		$finish;
	end

endmodule
